@@ design/cftm_pkg.sv @@
// Shared constants, codes and helper functions of the card-fed teaching machine.
package cftm_pkg;

  localparam int MEM_WORDS  = 100;
  localparam int CARD_WORDS = 10;

  localparam int WORD_W    = 32;
  localparam int CTR_OUT_W = 7;
  localparam int DEC_W     = 8;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int BASE_W    = $clog2(MEM_WORDS + 1);
  localparam int PTR_W     = $clog2(CARD_WORDS + 1);
  localparam int SUM_W     = $clog2(MEM_WORDS + CARD_WORDS + 1);

  typedef enum logic [1:0] {
    ACT_JOB  = 2'd0,
    ACT_PROG = 2'd1,
    ACT_STEP = 2'd2,
    ACT_DATA = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NEED_DATA    = 3'd1,
    ST_OUTPUT       = 3'd2,
    ST_HALTED       = 3'd3,
    ST_MEM_EXCEEDED = 3'd4,
    ST_BAD_ADDR     = 3'd5,
    ST_OUT_OF_DATA  = 3'd6,
    ST_BAD_ACTION   = 3'd7
  } status_t;

  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // One bit per non-zero character, first character in the top bit.
  function automatic logic [3:0] byte_mask_of(input logic [WORD_W-1:0] w);
    logic [3:0] m;
    m[3] = (w[31:24] != 8'd0);
    m[2] = (w[23:16] != 8'd0);
    m[1] = (w[15:8]  != 8'd0);
    m[0] = (w[7:0]   != 8'd0);
    return m;
  endfunction

endpackage

@@ design/cftm_if.sv @@
// Command and response channel interfaces of the card-fed teaching machine.
interface cftm_in_if;
  logic                           valid;
  logic                           ready;
  cftm_pkg::action_t              action;
  logic [cftm_pkg::WORD_W-1:0]    word;
  logic                           card_end;
  logic                           no_data;

  modport source (output valid, output action, output word, output card_end,
                  output no_data, input ready);
  modport sink   (input valid, input action, input word, input card_end,
                  input no_data, output ready);
endinterface

interface cftm_out_if;
  logic                            valid;
  logic                            ready;
  cftm_pkg::status_t               status;
  logic [cftm_pkg::WORD_W-1:0]     out_word;
  logic [3:0]                      byte_mask;
  logic                            last;
  logic [cftm_pkg::CTR_OUT_W-1:0]  counter_now;

  modport source (output valid, output status, output out_word, output byte_mask,
                  output last, output counter_now, input ready);
  modport sink   (input valid, input status, input out_word, input byte_mask,
                  input last, input counter_now, output ready);
endinterface

@@ design/cftm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module cftm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/card_fed_teaching_machine_core.sv @@
// Top level of the card-fed teaching machine: sequencer around the main store.
//
// The block takes command items on the cmd channel and returns result items on
// the rsp channel, both valid/ready. An item moves when valid and ready are high
// at a rising edge. Each command gives one result item, except a print step
// (PD), which gives one item for each word of a card, the final one with last.
//
// A job start, a program word or a data word is accepted in the idle state and
// passes to the result state, which loads the result register once it is
// free; the next command is then taken in the idle state. For a step, the
// instruction word is read from the store while the block waits for a command,
// decoded in the fetch cycle and answered from the result state. LR and CR
// need a second read of the store, through the operand states OPA and OPD.
// A print step reads each word of a card in PRD and hands it on from PWT once
// the result register is free, then moves to the next word.
//
// The result register parts the two channels: a new command is accepted while
// an earlier result still waits, and the sequencer stalls only when it has a
// fresh result and the register is still full. A stalled receiver thus holds
// the block at its next result and no item is lost.
//
// Reset (rst, synchronous) and a job start both clear all machine state. The
// store is cleared at once through a valid bit per word: a word never written
// since then reads as zero, so no clearing pass is needed.
module card_fed_teaching_machine_core (
  input  logic          clk,
  input  logic          rst,
  cftm_in_if.sink       cmd,
  cftm_out_if.source    rsp
);

  import cftm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_OPA   = 7'b0000100,
    S_OPD   = 7'b0001000,
    S_PRD   = 7'b0010000,
    S_PWT   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state;

  // Machine state.
  logic [WORD_W-1:0]  general_reg;
  logic               toggle_flag;
  logic [ADDR_W-1:0]  instr_counter;
  logic [PTR_W-1:0]   load_ptr;
  logic [BASE_W-1:0]  card_base;
  logic               await_data;
  logic [ADDR_W-1:0]  read_base;
  logic [PTR_W-1:0]   read_index;
  logic               halted;

  // Sequencer working registers.
  logic [ADDR_W-1:0]  op_addr;
  logic               op_is_cr;
  logic [ADDR_W-1:0]  pbase;
  logic [PTR_W-1:0]   pidx;
  status_t            resp_status;

  // Store and its valid bits.
  logic [MEM_WORDS-1:0] valid;
  logic                 rd_vld;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;
  logic [WORD_W-1:0]    mem_word;

  logic cmd_acc;
  logic out_free;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  cftm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mem_word = rd_vld ? ram_rdata : '0;

  // Read address. While idle the store is read at the instruction counter, so
  // the instruction word is ready in the fetch cycle that follows a step. A
  // print keeps its address while it waits, so a stalled word is read again.
  always_comb begin
    case (state)
      S_OPA:        ram_raddr = op_addr;
      S_PRD, S_PWT: ram_raddr = ADDR_W'(SUM_W'(pbase) + SUM_W'(pidx));
      default:      ram_raddr = instr_counter;
    endcase
  end

  // Instruction decode of the word read in the fetch cycle.
  logic [7:0]       op0, op1, d1, d0;
  logic [DEC_W-1:0] dv1, dv0, tens, full;
  logic             is_gdpd, is_reg, gp_bad, rg_bad;
  logic [ADDR_W-1:0] ctr_inc;

  always_comb begin
    op0  = mem_word[31:24];
    op1  = mem_word[23:16];
    d1   = mem_word[15:8];
    d0   = mem_word[7:0];
    dv1  = d1 - CH_ZERO;
    dv0  = d0 - CH_ZERO;
    tens = (dv1 << 3) + (dv1 << 1);
    full = tens + dv0;
    is_gdpd = ((op0 == CH_G) || (op0 == CH_P)) && (op1 == CH_D);
    is_reg  = (((op0 == CH_L) || (op0 == CH_S) || (op0 == CH_C)) && (op1 == CH_R)) ||
              ((op0 == CH_B) && (op1 == CH_T));
    gp_bad  = !is_digit(d1) || ((tens + DEC_W'(CARD_WORDS)) > DEC_W'(MEM_WORDS));
    rg_bad  = !is_digit(d1) || !is_digit(d0) || (full >= DEC_W'(MEM_WORDS));
    ctr_inc = (instr_counter == ADDR_W'(MEM_WORDS - 1)) ? '0 : instr_counter + 1'b1;
  end

  // Addresses of program and data words.
  logic [SUM_W-1:0] prog_addr, data_addr, base_adv;

  assign prog_addr = SUM_W'(card_base) + SUM_W'(load_ptr);
  assign data_addr = SUM_W'(read_base) + SUM_W'(read_index);
  assign base_adv  = SUM_W'(card_base) + SUM_W'(CARD_WORDS);

  // Single write port: card words while idle, SR in the fetch cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(prog_addr);
    ram_wdata = cmd.word;
    if (cmd_acc && (cmd.action == ACT_PROG)) begin
      ram_we = (SUM_W'(card_base) < SUM_W'(MEM_WORDS)) &&
               (load_ptr < PTR_W'(CARD_WORDS)) && (prog_addr < SUM_W'(MEM_WORDS));
    end else if (cmd_acc && (cmd.action == ACT_DATA)) begin
      ram_waddr = ADDR_W'(data_addr);
      ram_we    = await_data && !cmd.no_data && (read_index < PTR_W'(CARD_WORDS)) &&
                  (data_addr < SUM_W'(MEM_WORDS));
    end else if ((state == S_FETCH) && !is_gdpd && is_reg && !rg_bad &&
                 (op0 == CH_S)) begin
      ram_waddr = ADDR_W'(full);
      ram_wdata = general_reg;
      ram_we    = 1'b1;
    end
  end

  // Valid bits: a job start forgets every word at once.
  always_ff @(posedge clk) begin
    if (rst || (cmd_acc && (cmd.action == ACT_JOB))) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[ram_waddr] <= 1'b1;
    end
    rd_vld <= valid[ram_raddr];
  end

  // Sequencer and machine state. Accesses to the store never overlap on one
  // word: each write lands before the next read is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      general_reg   <= '0;
      toggle_flag   <= 1'b0;
      instr_counter <= '0;
      load_ptr      <= '0;
      card_base     <= '0;
      await_data    <= 1'b0;
      read_base     <= '0;
      read_index    <= '0;
      halted        <= 1'b0;
      resp_status   <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            state <= S_RESP;
            case (cmd.action)
              ACT_JOB: begin
                general_reg   <= '0;
                toggle_flag   <= 1'b0;
                instr_counter <= '0;
                load_ptr      <= '0;
                card_base     <= '0;
                await_data    <= 1'b0;
                read_base     <= '0;
                read_index    <= '0;
                halted        <= 1'b0;
                resp_status   <= ST_OK;
              end
              ACT_PROG: begin
                if (SUM_W'(card_base) >= SUM_W'(MEM_WORDS)) begin
                  resp_status <= ST_MEM_EXCEEDED;
                end else begin
                  resp_status <= ST_OK;
                  if (cmd.card_end) begin
                    load_ptr  <= '0;
                    card_base <= (base_adv > SUM_W'(MEM_WORDS)) ?
                                 BASE_W'(MEM_WORDS) : BASE_W'(base_adv);
                  end else if (load_ptr < PTR_W'(CARD_WORDS)) begin
                    load_ptr <= load_ptr + 1'b1;
                  end
                end
              end
              ACT_STEP: begin
                if (halted) begin
                  resp_status <= ST_HALTED;
                end else if (await_data) begin
                  resp_status <= ST_NEED_DATA;
                end else begin
                  state <= S_FETCH;
                end
              end
              default: begin
                // Data word.
                if (!await_data) begin
                  resp_status <= ST_BAD_ACTION;
                end else if (cmd.no_data) begin
                  await_data  <= 1'b0;
                  resp_status <= ST_OUT_OF_DATA;
                end else begin
                  if (read_index < PTR_W'(CARD_WORDS)) begin
                    read_index <= read_index + 1'b1;
                  end
                  if (cmd.card_end) begin
                    await_data  <= 1'b0;
                    resp_status <= ST_OK;
                  end else begin
                    resp_status <= ST_NEED_DATA;
                  end
                end
              end
            endcase
          end
        end
        S_FETCH: begin
          instr_counter <= ctr_inc;
          state         <= S_RESP;
          resp_status   <= ST_OK;
          if (is_gdpd) begin
            if (gp_bad) begin
              resp_status <= ST_BAD_ADDR;
            end else if (op0 == CH_G) begin
              await_data  <= 1'b1;
              read_base   <= ADDR_W'(tens);
              read_index  <= '0;
              resp_status <= ST_NEED_DATA;
            end else begin
              pbase <= ADDR_W'(tens);
              pidx  <= '0;
              state <= S_PRD;
            end
          end else if (is_reg) begin
            if (rg_bad) begin
              resp_status <= ST_BAD_ADDR;
            end else if ((op0 == CH_L) || (op0 == CH_C)) begin
              op_addr  <= ADDR_W'(full);
              op_is_cr <= (op0 == CH_C);
              state    <= S_OPA;
            end else if ((op0 == CH_B) && toggle_flag) begin
              instr_counter <= ADDR_W'(full);
            end
          end else if (op0 == CH_H) begin
            halted      <= 1'b1;
            resp_status <= ST_HALTED;
          end
        end
        S_OPA: begin
          state <= S_OPD;
        end
        S_OPD: begin
          if (op_is_cr) begin
            toggle_flag <= (general_reg == mem_word);
          end else begin
            general_reg <= mem_word;
          end
          resp_status <= ST_OK;
          state       <= S_RESP;
        end
        S_PRD: begin
          state <= S_PWT;
        end
        S_PWT: begin
          if (out_free) begin
            if (pidx == PTR_W'(CARD_WORDS - 1)) begin
              state <= S_IDLE;
            end else begin
              pidx  <= pidx + 1'b1;
              state <= S_PRD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      rsp.valid <= 1'b1;
    end else if ((state == S_PWT) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      rsp.status      <= resp_status;
      rsp.out_word    <= '0;
      rsp.byte_mask   <= '0;
      rsp.last        <= 1'b1;
      rsp.counter_now <= CTR_OUT_W'(instr_counter);
    end else if ((state == S_PWT) && out_free) begin
      rsp.status      <= ST_OUTPUT;
      rsp.out_word    <= mem_word;
      rsp.byte_mask   <= byte_mask_of(mem_word);
      rsp.last        <= (pidx == PTR_W'(CARD_WORDS - 1));
      rsp.counter_now <= CTR_OUT_W'(instr_counter);
    end
  end

  // The machine can never be halted and waiting for data at once.
  a_halt_await_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(halted && await_data))
    else $error("halted and await_data set together");

  // The instruction counter stays inside the store.
  a_counter_in_range: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(instr_counter) < SUM_W'(MEM_WORDS))
    else $error("instruction counter past the store");

  // The print index stays within one card while printing.
  a_print_index: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PRD) || (state == S_PWT)) |-> (pidx < PTR_W'(CARD_WORDS)))
    else $error("print index past the card");

  // A step on a running machine goes to the fetch cycle.
  a_step_fetches: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.action == ACT_STEP) && !halted && !await_data)
      |=> (state == S_FETCH))
    else $error("step did not fetch");

  // The card base never passes the end of the store.
  a_card_base: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(card_base) <= SUM_W'(MEM_WORDS))
    else $error("card base past the store");

endmodule
